// File: rtl/assert_macros.svh
// Assertion macros used by the checker file smm_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SMM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smm assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SMM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smm assertion failed");

`endif

// File: rtl/smm_pkg.sv
// Package for the small matrix multiply block: widths, codes, states and control structs.
`default_nettype none

package smm_pkg;

    localparam int INNER_SIZE_DEF  = 3;
    localparam int OUT_COLUMNS_DEF = 4;

    localparam int DATA_W = 32;
    localparam int IDX_W  = 2;
    localparam int COL_W  = 2;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_LEFT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_EMIT
    } smm_state_t;

    typedef struct packed {
        logic load_val;
        logic mul_en;
        logic acc_en;
        logic restart;
        logic rotate;
    } mac_ctl_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } store_ctl_t;

    typedef struct packed {
        logic             load;
        logic [COL_W-1:0] column;
        logic             row_done;
        logic             matrix_done;
    } emit_t;

endpackage

`default_nettype wire

// File: rtl/small_matrix_multiply.sv
// Small matrix multiply: streams left-matrix rows against a stored right matrix.
// A load beat (command 0) writes one right-matrix entry.
// A left beat (command 1) keeps input stall high from its acceptance until
// it is fully handled, so the next beat cannot go in before then: one shared
// 32x32 multiply-accumulate walks the columns
// one per cycle behind the store's registered read port. A left beat
// carrying the last inner index then emits OUT_COLUMNS result beats, one
// per cycle when the output is not stalled, with input stall still high;
// row_done marks the last column and matrix_done marks it too when last_row
// was set. Sums wrap modulo 2^32.
// Out-of-range loads and left elements are dropped. No clearing pass is run.
`default_nettype none

module small_matrix_multiply
    import smm_pkg::*;
#(
    parameter int INNER_SIZE  = INNER_SIZE_DEF,
    parameter int OUT_COLUMNS = OUT_COLUMNS_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic                     command,
    input  wire logic        [IDX_W-1:0]  inner_index,
    input  wire logic        [COL_W-1:0]  column_index,
    input  wire logic signed [DATA_W-1:0] value,
    input  wire logic                     last_row,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic             [COL_W-1:0]  column,
    output logic signed      [DATA_W-1:0] sum,
    output logic                          row_done,
    output logic                          matrix_done
);

    localparam int DEPTH = INNER_SIZE * OUT_COLUMNS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    store_ctl_t        store_ctl;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;
    logic [DATA_W-1:0] rd_data;
    mac_ctl_t          mac_ctl;
    emit_t             emit;
    logic [DATA_W-1:0] head;
    logic              out_free;

    logic              out_valid_reg, out_valid_next;
    logic [COL_W-1:0]  column_reg;
    logic [DATA_W-1:0] sum_reg;
    logic              row_done_reg;
    logic              matrix_done_reg;

    assign out_free = !out_valid_reg || !out_stall;

    smm_seq #(
        .INNER_SIZE  (INNER_SIZE),
        .OUT_COLUMNS (OUT_COLUMNS),
        .AW          (AW)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .command      (command),
        .inner_index  (inner_index),
        .column_index (column_index),
        .last_row     (last_row),
        .out_free     (out_free),
        .in_stall     (in_stall),
        .store_ctl    (store_ctl),
        .wr_addr      (wr_addr),
        .rd_addr      (rd_addr),
        .mac_ctl      (mac_ctl),
        .emit         (emit)
    );

    smm_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .ctl     (store_ctl),
        .wr_addr (wr_addr),
        .wr_data (value),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    smm_mac #(
        .OUT_COLUMNS (OUT_COLUMNS)
    ) u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (mac_ctl),
        .value   (value),
        .entry   (rd_data),
        .head    (head)
    );

    always_comb
    begin
        if (emit.load)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.load)
        begin
            column_reg      <= emit.column;
            sum_reg         <= head;
            row_done_reg    <= emit.row_done;
            matrix_done_reg <= emit.matrix_done;
        end
    end

    assign out_valid   = out_valid_reg;
    assign column      = column_reg;
    assign sum         = sum_reg;
    assign row_done    = row_done_reg;
    assign matrix_done = matrix_done_reg;

endmodule

`default_nettype wire

// File: rtl/smm_store.sv
// Right-matrix store: one write port, one registered read port.
`default_nettype none

module smm_store
    import smm_pkg::*;
#(
    parameter int DEPTH = INNER_SIZE_DEF * OUT_COLUMNS_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  wire logic              clk,
    input  wire store_ctl_t        ctl,
    input  wire logic [AW-1:0]     wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic [AW-1:0]     rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: rtl/smm_mac.sv
// Shared multiply-accumulate unit with a rotating ring of column sums.
`default_nettype none

module smm_mac
    import smm_pkg::*;
#(
    parameter int OUT_COLUMNS = OUT_COLUMNS_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire mac_ctl_t          ctl,
    input  wire logic [DATA_W-1:0] value,
    input  wire logic [DATA_W-1:0] entry,
    output logic      [DATA_W-1:0] head
);

    logic [DATA_W-1:0] val_reg;
    logic [DATA_W-1:0] prod_reg;
    logic [DATA_W-1:0] sums_reg  [OUT_COLUMNS];
    logic [DATA_W-1:0] sums_next [OUT_COLUMNS];
    logic [DATA_W-1:0] new_head;

    always_ff @(posedge clk)
    begin
        if (ctl.load_val)
        begin
            val_reg <= value;
        end
        if (ctl.mul_en)
        begin
            prod_reg <= DATA_W'(val_reg * entry);
        end
    end

    // head of the ring is always the column being worked on
    always_comb
    begin
        new_head = ctl.restart ? prod_reg : DATA_W'(sums_reg[0] + prod_reg);
        for (int i = 0; i < OUT_COLUMNS - 1; i++)
        begin
            sums_next[i] = sums_reg[i + 1];
        end
        sums_next[OUT_COLUMNS - 1] = ctl.acc_en ? new_head : sums_reg[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < OUT_COLUMNS; i++)
            begin
                sums_reg[i] <= '0;
            end
        end
        else if (ctl.acc_en || ctl.rotate)
        begin
            sums_reg <= sums_next;
        end
    end

    assign head = sums_reg[0];

endmodule

`default_nettype wire

// File: rtl/smm_seq.sv
// Sequencer: decodes input beats, steps the shared MAC over columns, drives emission.
`default_nettype none

module smm_seq
    import smm_pkg::*;
#(
    parameter int INNER_SIZE  = INNER_SIZE_DEF,
    parameter int OUT_COLUMNS = OUT_COLUMNS_DEF,
    parameter int AW          = 1
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic             command,
    input  wire logic [IDX_W-1:0] inner_index,
    input  wire logic [COL_W-1:0] column_index,
    input  wire logic             last_row,
    input  wire logic             out_free,
    output logic                  in_stall,
    output store_ctl_t            store_ctl,
    output logic      [AW-1:0]    wr_addr,
    output logic      [AW-1:0]    rd_addr,
    output mac_ctl_t              mac_ctl,
    output emit_t                 emit
);

    localparam int CW = (OUT_COLUMNS > 1) ? $clog2(OUT_COLUMNS) : 1;
    localparam logic [CW-1:0] LAST_COL = CW'(OUT_COLUMNS - 1);

    smm_state_t       state_reg, state_next;
    logic [CW-1:0]    iss_cnt_reg, iss_cnt_next;
    logic             iss_done_reg, iss_done_next;
    logic             rd_vld_reg, rd_vld_next;
    logic             mul_vld_reg, mul_vld_next;
    logic [AW-1:0]    addr_reg, addr_next;
    logic             restart_reg, restart_next;
    logic             emit_reg, emit_next;
    logic             last_reg, last_next;
    logic [CW-1:0]    ecnt_reg, ecnt_next;
    logic [COL_W-1:0] col_reg, col_next;

    logic index_ok;
    logic column_ok;

    assign index_ok  = int'(inner_index) < INNER_SIZE;
    assign column_ok = int'(column_index) < OUT_COLUMNS;
    assign wr_addr   = AW'(int'(inner_index) * OUT_COLUMNS + int'(column_index));
    assign rd_addr   = addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            iss_cnt_reg  <= '0;
            iss_done_reg <= 1'b0;
            rd_vld_reg   <= 1'b0;
            mul_vld_reg  <= 1'b0;
            addr_reg     <= '0;
            restart_reg  <= 1'b0;
            emit_reg     <= 1'b0;
            last_reg     <= 1'b0;
            ecnt_reg     <= '0;
            col_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            iss_cnt_reg  <= iss_cnt_next;
            iss_done_reg <= iss_done_next;
            rd_vld_reg   <= rd_vld_next;
            mul_vld_reg  <= mul_vld_next;
            addr_reg     <= addr_next;
            restart_reg  <= restart_next;
            emit_reg     <= emit_next;
            last_reg     <= last_next;
            ecnt_reg     <= ecnt_next;
            col_reg      <= col_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        iss_cnt_next  = iss_cnt_reg;
        iss_done_next = iss_done_reg;
        rd_vld_next   = 1'b0;
        mul_vld_next  = rd_vld_reg;
        addr_next     = addr_reg;
        restart_next  = restart_reg;
        emit_next     = emit_reg;
        last_next     = last_reg;
        ecnt_next     = ecnt_reg;
        col_next      = col_reg;

        in_stall      = 1'b1;
        store_ctl     = '0;
        mac_ctl       = '0;
        emit          = '0;

        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid && index_ok)
                begin
                    if (command == CMD_LOAD)
                    begin
                        store_ctl.wr_en = column_ok;
                    end
                    else
                    begin
                        mac_ctl.load_val = 1'b1;
                        addr_next        = AW'(int'(inner_index) * OUT_COLUMNS);
                        iss_cnt_next     = '0;
                        iss_done_next    = 1'b0;
                        restart_next     = (inner_index == '0);
                        emit_next        = (int'(inner_index) == INNER_SIZE - 1);
                        last_next        = last_row;
                        state_next       = ST_MAC;
                    end
                end
            end

            ST_MAC:
            begin
                store_ctl.rd_en = !iss_done_reg;
                rd_vld_next     = !iss_done_reg;
                mac_ctl.mul_en  = rd_vld_reg;
                mac_ctl.acc_en  = mul_vld_reg;
                mac_ctl.restart = restart_reg;
                if (!iss_done_reg)
                begin
                    addr_next = AW'(addr_reg + 1'b1);
                    if (iss_cnt_reg == LAST_COL)
                    begin
                        iss_done_next = 1'b1;
                    end
                    else
                    begin
                        iss_cnt_next = CW'(iss_cnt_reg + 1'b1);
                    end
                end
                else if (!rd_vld_reg && !mul_vld_reg)
                begin
                    ecnt_next  = '0;
                    col_next   = '0;
                    state_next = emit_reg ? ST_EMIT : ST_IDLE;
                end
            end

            ST_EMIT:
            begin
                emit.column      = col_reg;
                emit.row_done    = (ecnt_reg == LAST_COL);
                emit.matrix_done = (ecnt_reg == LAST_COL) && last_reg;
                if (out_free)
                begin
                    emit.load      = 1'b1;
                    mac_ctl.rotate = 1'b1;
                    ecnt_next      = CW'(ecnt_reg + 1'b1);
                    col_next       = COL_W'(col_reg + 1'b1);
                    if (ecnt_reg == LAST_COL)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/smm_checker.sv
// Port-level checker for small_matrix_multiply and its bind.
`default_nettype none
`include "assert_macros.svh"

module smm_checker
    import smm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_stall,
    input  wire logic              out_valid,
    input  wire logic              out_stall,
    input  wire logic [COL_W-1:0]  column,
    input  wire logic [DATA_W-1:0] sum,
    input  wire logic              row_done,
    input  wire logic              matrix_done
);

    `SMM_ASSERT_NOW(a_matrix_end_is_row_end, out_valid && matrix_done, row_done)

    `SMM_ASSERT_NOW(a_busy_mid_row, out_valid && !out_stall && !row_done, in_stall)

    `SMM_ASSERT_NEXT(a_columns_back_to_back, out_valid && !out_stall && !row_done,
        out_valid && (column == COL_W'($past(column) + 1'b1)))

    `SMM_ASSERT_NEXT(a_stalled_beat_holds, out_valid && out_stall,
        out_valid && $stable(sum) && $stable(column))

endmodule

bind small_matrix_multiply smm_checker u_smm_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .column      (column),
    .sum         (sum),
    .row_done    (row_done),
    .matrix_done (matrix_done)
);

`default_nettype wire
